[rtl/core/aarm_pkg.sv]
// Package for the axis-angle rotation matrix block: types, constants and tables.
package aarm_pkg;

  localparam int CordicSteps = 16;
  localparam int FracBits = 14;
  localparam int unsigned GainQ30 = 32'd652032874;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic [15:0]        angle_turns;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] row0_col0;
    logic signed [15:0] row0_col1;
    logic signed [15:0] row0_col2;
    logic signed [15:0] row1_col0;
    logic signed [15:0] row1_col1;
    logic signed [15:0] row1_col2;
    logic signed [15:0] row2_col0;
    logic signed [15:0] row2_col1;
    logic signed [15:0] row2_col2;
  } out_item_t;

  // One CORDIC stage's working state; the axis rides along.
  typedef struct packed {
    logic signed [32:0] cx;
    logic signed [32:0] cy;
    logic signed [33:0] cz;
    logic               flip;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } cordic_t;

  // Axis with finished c, s, t in Q.30.
  typedef struct packed {
    logic signed [32:0] c;
    logic signed [32:0] s;
    logic signed [32:0] t;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } trig_t;

  function automatic logic signed [33:0] atan_turns(input logic [4:0] i);
    case (i)
      5'd0:  atan_turns = 34'sd536870912;
      5'd1:  atan_turns = 34'sd316933406;
      5'd2:  atan_turns = 34'sd167458907;
      5'd3:  atan_turns = 34'sd85004756;
      5'd4:  atan_turns = 34'sd42667331;
      5'd5:  atan_turns = 34'sd21354465;
      5'd6:  atan_turns = 34'sd10679838;
      5'd7:  atan_turns = 34'sd5340245;
      5'd8:  atan_turns = 34'sd2670163;
      5'd9:  atan_turns = 34'sd1335087;
      5'd10: atan_turns = 34'sd667544;
      5'd11: atan_turns = 34'sd333772;
      5'd12: atan_turns = 34'sd166886;
      5'd13: atan_turns = 34'sd83443;
      5'd14: atan_turns = 34'sd41722;
      5'd15: atan_turns = 34'sd20861;
      5'd16: atan_turns = 34'sd10430;
      5'd17: atan_turns = 34'sd5215;
      5'd18: atan_turns = 34'sd2608;
      5'd19: atan_turns = 34'sd1304;
      5'd20: atan_turns = 34'sd652;
      5'd21: atan_turns = 34'sd326;
      5'd22: atan_turns = 34'sd163;
      5'd23: atan_turns = 34'sd81;
      default: atan_turns = 34'sd0;
    endcase
  endfunction

endpackage

[rtl/core/aarm_cordic.sv]
// Unrolled rotation-mode CORDIC: one register stage per iteration, giving c, s and t.
module aarm_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  aarm_pkg::in_item_t  in_item,
  output logic                out_vld,
  output aarm_pkg::trig_t     out_trig
);

  localparam int N = aarm_pkg::CordicSteps;

  aarm_pkg::cordic_t st_r [N+1];
  logic [N:0]        vld_r;
  aarm_pkg::cordic_t st_nxt [N+1];
  logic [31:0]       th;
  logic              flip;
  logic [31:0]       thr;

  always_comb begin
    th = {in_item.angle_turns, 16'd0};
    flip = (th[31:30] == 2'b01) || (th[31:30] == 2'b10);
    thr = flip ? (th - 32'h8000_0000) : th;
    st_nxt[0].cx = 33'(aarm_pkg::GainQ30);
    st_nxt[0].cy = '0;
    st_nxt[0].cz = 34'(signed'(thr));
    st_nxt[0].flip = flip;
    st_nxt[0].ax = in_item.axis_x;
    st_nxt[0].ay = in_item.axis_y;
    st_nxt[0].az = in_item.axis_z;
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_comb begin
      st_nxt[i+1] = st_r[i];
      if (!st_r[i].cz[33]) begin
        st_nxt[i+1].cx = st_r[i].cx - (st_r[i].cy >>> i);
        st_nxt[i+1].cy = st_r[i].cy + (st_r[i].cx >>> i);
        st_nxt[i+1].cz = st_r[i].cz - aarm_pkg::atan_turns(5'(i));
      end else begin
        st_nxt[i+1].cx = st_r[i].cx + (st_r[i].cy >>> i);
        st_nxt[i+1].cy = st_r[i].cy - (st_r[i].cx >>> i);
        st_nxt[i+1].cz = st_r[i].cz + aarm_pkg::atan_turns(5'(i));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[N-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= N; k++) st_r[k] <= st_nxt[k];
    end
  end

  logic signed [32:0] c_fin;
  logic signed [32:0] s_fin;

  always_comb begin
    c_fin = st_r[N].flip ? -st_r[N].cx : st_r[N].cx;
    s_fin = st_r[N].flip ? -st_r[N].cy : st_r[N].cy;
    out_trig.c = c_fin;
    out_trig.s = s_fin;
    out_trig.t = 33'sd1073741824 - c_fin;
    out_trig.ax = st_r[N].ax;
    out_trig.ay = st_r[N].ay;
    out_trig.az = st_r[N].az;
    out_vld = vld_r[N];
  end

endmodule

[rtl/core/aarm_matrix.sv]
// Product pipeline: axis products, times t and s, rounding, sum and saturation.
module aarm_matrix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  aarm_pkg::trig_t     in_trig,
  output logic                out_vld,
  output aarm_pkg::out_item_t out_item
);

  localparam int F = aarm_pkg::FracBits;

  // Stage A: pair products of the axis (six distinct).
  logic signed [31:0] p_r [6];
  logic signed [15:0] a_r [3];
  logic signed [32:0] c_a_r, s_a_r, t_a_r;
  // Stage B: products with t and s, and the cosine term rounded in stage A.
  logic signed [64:0] pt_r [6];
  logic signed [48:0] as_r [3];
  logic signed [32:0] cf_r;
  // Stage C: rounded terms.
  logic signed [32:0] rt_r [6];
  logic signed [18:0] rs_r [3];
  logic signed [32:0] cf2_r;
  // One valid bit for each of the four register stages.
  logic [3:0]         vld_r;
  logic [15:0]        e_r [9];

  logic signed [32:0] rt_nxt [6];
  logic signed [18:0] rs_nxt [3];
  logic signed [32:0] cf_nxt;
  logic signed [33:0] sum [9];
  logic [15:0]        e_nxt [9];

  function automatic logic [15:0] sat16(input logic signed [33:0] v);
    if (v > 34'sd32767) sat16 = 16'h7fff;
    else if (v < -34'sd32768) sat16 = 16'h8000;
    else sat16 = v[15:0];
  endfunction

  always_comb begin
    cf_nxt = (in_trig.c + (33'sd1 <<< (29 - F))) >>> (30 - F);
    for (int k = 0; k < 6; k++) begin
      rt_nxt[k] = 33'((pt_r[k] + (65'sd1 <<< (F + 29))) >>> (F + 30));
    end
    for (int k = 0; k < 3; k++) begin
      rs_nxt[k] = 19'((as_r[k] + (49'sd1 <<< 29)) >>> 30);
    end
    // rt: 0 xx, 1 xy, 2 xz, 3 yy, 4 yz, 5 zz; rs: 0 x*s, 1 y*s, 2 z*s.
    sum[0] = 34'(rt_r[0]) + 34'(cf2_r);
    sum[1] = 34'(rt_r[1]) + 34'(rs_r[2]);
    sum[2] = 34'(rt_r[2]) - 34'(rs_r[1]);
    sum[3] = 34'(rt_r[1]) - 34'(rs_r[2]);
    sum[4] = 34'(rt_r[3]) + 34'(cf2_r);
    sum[5] = 34'(rt_r[4]) + 34'(rs_r[0]);
    sum[6] = 34'(rt_r[2]) + 34'(rs_r[1]);
    sum[7] = 34'(rt_r[4]) - 34'(rs_r[0]);
    sum[8] = 34'(rt_r[5]) + 34'(cf2_r);
    for (int k = 0; k < 9; k++) e_nxt[k] = sat16(sum[k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0] <= in_trig.ax * in_trig.ax;
      p_r[1] <= in_trig.ax * in_trig.ay;
      p_r[2] <= in_trig.ax * in_trig.az;
      p_r[3] <= in_trig.ay * in_trig.ay;
      p_r[4] <= in_trig.ay * in_trig.az;
      p_r[5] <= in_trig.az * in_trig.az;
      a_r[0] <= in_trig.ax;
      a_r[1] <= in_trig.ay;
      a_r[2] <= in_trig.az;
      c_a_r <= cf_nxt;
      s_a_r <= in_trig.s;
      t_a_r <= in_trig.t;
      for (int k = 0; k < 6; k++) pt_r[k] <= 65'(p_r[k]) * 65'(t_a_r);
      for (int k = 0; k < 3; k++) as_r[k] <= 49'(a_r[k]) * 49'(s_a_r);
      cf_r <= c_a_r;
      rt_r <= rt_nxt;
      rs_r <= rs_nxt;
      cf2_r <= cf_r;
      e_r <= e_nxt;
    end
  end

  always_comb begin
    out_vld = vld_r[3];
    out_item.row0_col0 = e_r[0];
    out_item.row0_col1 = e_r[1];
    out_item.row0_col2 = e_r[2];
    out_item.row1_col0 = e_r[3];
    out_item.row1_col1 = e_r[4];
    out_item.row1_col2 = e_r[5];
    out_item.row2_col0 = e_r[6];
    out_item.row2_col1 = e_r[7];
    out_item.row2_col2 = e_r[8];
  end

endmodule

[rtl/core/axis_angle_rotation_matrix.sv]
// Top level of the axis-angle to 3x3 rotation matrix pipeline.
// Takes one item per cycle unless the output stalls, and returns one result item
// per input item, in order. There is one register per CORDIC iteration (16), one
// for the input of the CORDIC, three for the product and rounding stages and one
// for the final sum and saturation. The whole pipeline advances together; it
// holds when the output register is full and not taken, so nothing is lost.
module axis_angle_rotation_matrix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  aarm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output aarm_pkg::out_item_t out_data
);

  logic            adv;
  logic            trig_vld;
  aarm_pkg::trig_t trig;

  // The pipeline moves whenever its last stage is empty or being taken.
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  aarm_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_valid),
    .in_item  (in_data),
    .out_vld  (trig_vld),
    .out_trig (trig)
  );

  aarm_matrix u_matrix (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (trig_vld),
    .in_trig  (trig),
    .out_vld  (out_valid),
    .out_item (out_data)
  );

endmodule

[test/tb.sv]
// Testbench for the axis-angle rotation matrix pipeline.
`timescale 1ns / 100ps

module tb;

  localparam int Latency = 21;
  localparam longint CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  aarm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  aarm_pkg::out_item_t out_data;

  aarm_pkg::out_item_t matrix_q[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  longint cycle = 0;
  bit quiet = 1'b0;
  int hold_cycles = 0;

  axis_angle_rotation_matrix uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CycleLimit) begin
      $display("timeout after %0d cycles", cycle);
      $display("axis_angle_rotation_matrix regression: fail");
      $finish;
    end
  end

  function automatic longint floor_shift(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic longint round_to(longint v, int sh);
    if (sh == 0) return v;
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint arctan_turn(int i);
    longint tbl[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                        10679838, 5340245, 2670163, 1335087, 667544, 333772,
                        166886, 83443, 41722, 20861, 10430, 5215,
                        2608, 1304, 652, 326, 163, 81};
    return tbl[i];
  endfunction

  function automatic aarm_pkg::out_item_t rotation_matrix(aarm_pkg::in_item_t it);
    int fb;
    int steps;
    logic [31:0] th;
    bit flip;
    longint cx, cy, cz, dx, dy, c, s, t, cf, xs, ys, zs, ax, ay, az;
    aarm_pkg::out_item_t r;
    fb = (aarm_pkg::FracBits > 30) ? 30 : aarm_pkg::FracBits;
    steps = (aarm_pkg::CordicSteps > 24) ? 24 : aarm_pkg::CordicSteps;
    th = {it.angle_turns, 16'h0000};
    flip = (th[31:30] == 2'b01) || (th[31:30] == 2'b10);
    if (flip) th = th - 32'h8000_0000;
    cz = longint'(signed'(th));
    cx = aarm_pkg::GainQ30;
    cy = 0;
    for (int i = 0; i < steps; i++) begin
      dx = floor_shift(cy, i);
      dy = floor_shift(cx, i);
      if (cz >= 0) begin
        cx -= dx; cy += dy; cz -= arctan_turn(i);
      end else begin
        cx += dx; cy -= dy; cz += arctan_turn(i);
      end
    end
    c = flip ? -cx : cx;
    s = flip ? -cy : cy;
    t = (64'sd1 <<< 30) - c;
    ax = it.axis_x; ay = it.axis_y; az = it.axis_z;
    cf = round_to(c, 30 - fb);
    xs = round_to(ax * s, 30);
    ys = round_to(ay * s, 30);
    zs = round_to(az * s, 30);
    r.row0_col0 = clamp16(round_to(ax * ax * t, fb + 30) + cf);
    r.row0_col1 = clamp16(round_to(ax * ay * t, fb + 30) + zs);
    r.row0_col2 = clamp16(round_to(ax * az * t, fb + 30) - ys);
    r.row1_col0 = clamp16(round_to(ay * ax * t, fb + 30) - zs);
    r.row1_col1 = clamp16(round_to(ay * ay * t, fb + 30) + cf);
    r.row1_col2 = clamp16(round_to(ay * az * t, fb + 30) + xs);
    r.row2_col0 = clamp16(round_to(az * ax * t, fb + 30) + ys);
    r.row2_col1 = clamp16(round_to(az * ay * t, fb + 30) - xs);
    r.row2_col2 = clamp16(round_to(az * az * t, fb + 30) + cf);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  // Receiver: random stalls, a quiet stretch, and a forced long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      aarm_pkg::out_item_t e;
      if (matrix_q.size() == 0) begin
        errors++;
        $display("result %0d arrived with nothing expected", results_seen);
      end else begin
        e = matrix_q.pop_front();
        if (out_data.row0_col0 !== e.row0_col0)
          report_mismatch("row0_col0", out_data.row0_col0, e.row0_col0);
        if (out_data.row0_col1 !== e.row0_col1)
          report_mismatch("row0_col1", out_data.row0_col1, e.row0_col1);
        if (out_data.row0_col2 !== e.row0_col2)
          report_mismatch("row0_col2", out_data.row0_col2, e.row0_col2);
        if (out_data.row1_col0 !== e.row1_col0)
          report_mismatch("row1_col0", out_data.row1_col0, e.row1_col0);
        if (out_data.row1_col1 !== e.row1_col1)
          report_mismatch("row1_col1", out_data.row1_col1, e.row1_col1);
        if (out_data.row1_col2 !== e.row1_col2)
          report_mismatch("row1_col2", out_data.row1_col2, e.row1_col2);
        if (out_data.row2_col0 !== e.row2_col0)
          report_mismatch("row2_col0", out_data.row2_col0, e.row2_col0);
        if (out_data.row2_col1 !== e.row2_col1)
          report_mismatch("row2_col1", out_data.row2_col1, e.row2_col1);
        if (out_data.row2_col2 !== e.row2_col2)
          report_mismatch("row2_col2", out_data.row2_col2, e.row2_col2);
      end
      results_seen++;
    end
  end

  // Offers one item, idling first at random, and waits for its acceptance.
  task automatic send_item(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic [15:0] ang);
    aarm_pkg::in_item_t it;
    it = '{axis_x: x, axis_y: y, axis_z: z, angle_turns: ang};
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    matrix_q.push_back(rotation_matrix(it));
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  function automatic logic signed [15:0] random_axis();
    case ($urandom_range(9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sh8000;
      3: return 16'(signed'($urandom()));
      default: return 16'(int'($urandom_range(32768)) - 16384);
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] angs[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000,
                             16'hffff, 16'h3fff, 16'h7fff, 16'h2000};
    foreach (angs[i]) send_item(16'sd16384, 16'sd0, 16'sd0, angs[i]);
    send_item(16'sd0, 16'sd0, 16'sd16384, 16'h2000);
    send_item(16'sd0, -16'sd16384, 16'sd0, 16'h6000);
    send_item(16'sh8000, 16'sh8000, 16'sh8000, 16'h8000);
    send_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'h8000);
    send_item(16'sh7fff, 16'sh8000, 16'sh7fff, 16'h4000);
    send_item(16'sd0, 16'sd0, 16'sd0, 16'h1234);
    send_item(16'sd9459, 16'sd9459, 16'sd9459, 16'h5555);
    send_item(16'sh5555, 16'shaaaa, 16'sh5555, 16'haaaa);
    send_item(16'shaaaa, 16'sh5555, 16'shaaaa, 16'h5555);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_item(random_axis(), random_axis(), random_axis(), 16'($urandom()));
  endtask

  task automatic test_backpressure();
    hold_cycles <= 60;
    for (int i = 0; i < 50; i++)
      send_item(random_axis(), random_axis(), random_axis(), 16'($urandom()));
  endtask

  task automatic test_streaming(int n);
    quiet = 1'b1;
    test_random(n);
    quiet = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(600);
    test_backpressure();
    test_streaming(300);
    test_random(330);
    in_valid <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    $display("sent %0d axis-angle items, checked %0d matrices", items_sent, results_seen);
    $display("covered turn quadrants, saturating axes and a long output stall");
    if (errors == 0) begin
      $display("axis_angle_rotation_matrix regression: pass");
    end else begin
      $display("axis_angle_rotation_matrix regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/aarm_pkg.sv
rtl/core/aarm_cordic.sv
rtl/core/aarm_matrix.sv
rtl/core/axis_angle_rotation_matrix.sv
test/tb.sv
